// File: src/rfh_pkg.sv
// Shared constants and types for the reply frame hunter.
package rfh_pkg;

    // Frame layout
    localparam int FRAME_LENGTH_DEF = 11;
    localparam logic [7:0] HEADER_BYTE = 8'h55;
    localparam logic [7:0] REPLY_TYPE  = 8'h5F;

    // Control broadcast from the top level to every window cell
    typedef struct packed {
        logic shift;   // move bytes one place toward the oldest end
        logic clear;   // wipe the window after a matched frame
    } t_cell_ctrl;

endpackage

// File: src/rfh_cell.sv
// One byte cell of the sliding receive window.
module rfh_cell
    import rfh_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_ctrl i_ctrl,
    input  logic [7:0] i_byte,   // byte from the newer neighbor
    output logic [7:0] o_byte    // byte held, seen by the older neighbor
);

    logic [7:0] r_byte;
    logic [7:0] n_byte;

    // Clear wins over shift; otherwise hold
    always_comb begin
        n_byte = r_byte;
        if (i_ctrl.clear) begin
            n_byte = 8'h00;
        end else if (i_ctrl.shift) begin
            n_byte = i_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte <= 8'h00;
        end else begin
            r_byte <= n_byte;
        end
    end

    assign o_byte = r_byte;

endmodule

// File: src/rfh_out_buf.sv
// Output register with one skid entry for matched reply values.
module rfh_out_buf
    import rfh_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,     // new result; only while skid is empty
    input  logic [15:0] i_value,
    output logic        o_full,     // skid entry occupied
    output logic        o_valid,
    output logic [15:0] o_value,
    input  logic        i_stall
);

    logic        r_out_valid;
    logic [15:0] r_out_value;
    logic        r_skid_valid;
    logic [15:0] r_skid_value;
    logic        w_take;

    assign w_take = r_out_valid && !i_stall;

    // Control: output slot refills from skid first, then from a new result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || w_take) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_push;
            end
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (!r_out_valid || w_take) begin
            if (r_skid_valid) begin
                r_out_value <= r_skid_value;
            end else if (i_push) begin
                r_out_value <= i_value;
            end
        end else if (i_push) begin
            r_skid_value <= i_value;
        end
    end

    assign o_full  = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_value = r_out_value;

endmodule

// File: src/reply_frame_hunter.sv
// A matched reply value is registered in the output slot, or in the skid entry while i_stall holds it.
// Throughput: one byte per cycle; input stalls only while two results wait downstream.
// The window is a chain of byte cells; a running checksum register tracks the
// sum of all but the newest cell, so the match test is one add/subtract and compare.
// Reset (synchronous, active low) zeroes the window and checksum and drops
// any pending results; no clearing pass is needed.
module reply_frame_hunter
    import rfh_pkg::*;
#(
    parameter int FRAME_LENGTH = FRAME_LENGTH_DEF
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_reply_value
);

    logic [7:0]  w_win [FRAME_LENGTH];   // index 0 is the oldest byte
    logic        w_accept;
    logic        w_match;
    logic        w_full;
    logic [7:0]  w_sum_next;
    logic [15:0] w_value;
    logic [7:0]  r_sum;
    logic [7:0]  n_sum;
    t_cell_ctrl  w_ctrl;

    assign w_accept = i_valid && !w_full;
    assign o_stall  = w_full;

    // Checksum of the window after the shift, without the newest byte
    assign w_sum_next = r_sum - w_win[0] + w_win[FRAME_LENGTH-1];

    // Frame test on the post-shift window
    assign w_match = (w_win[1] == HEADER_BYTE) && (w_win[2] == REPLY_TYPE)
                  && (w_sum_next == i_rx_byte);
    assign w_value = {w_win[4], w_win[3]};

    assign w_ctrl.shift = w_accept;
    assign w_ctrl.clear = w_accept && w_match;

    // Cell chain: each cell loads from its newer neighbor
    genvar gi;
    generate
        for (gi = 0; gi < FRAME_LENGTH; gi++) begin : g_cell
            if (gi == FRAME_LENGTH - 1) begin : g_last
                rfh_cell u_cell (
                    .i_clk  (i_clk),
                    .i_rst_n(i_rst_n),
                    .i_ctrl (w_ctrl),
                    .i_byte (i_rx_byte),
                    .o_byte (w_win[gi])
                );
            end else begin : g_mid
                rfh_cell u_cell (
                    .i_clk  (i_clk),
                    .i_rst_n(i_rst_n),
                    .i_ctrl (w_ctrl),
                    .i_byte (w_win[gi+1]),
                    .o_byte (w_win[gi])
                );
            end
        end
    endgenerate

    // Running checksum
    always_comb begin
        n_sum = r_sum;
        if (w_accept) begin
            n_sum = w_match ? 8'h00 : w_sum_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= 8'h00;
        end else begin
            r_sum <= n_sum;
        end
    end

    rfh_out_buf u_out (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_accept && w_match),
        .i_value(w_value),
        .o_full (w_full),
        .o_valid(o_valid),
        .o_value(o_reply_value),
        .i_stall(i_stall)
    );

`ifndef SYNTHESIS
    // A match transfer always leaves a result visible next cycle
    a_match_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_match) |=> o_valid)
        else $error("matched frame produced no output");

    // Checksum restarts from zero after a match
    a_sum_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_match) |=> (r_sum == 8'h00))
        else $error("checksum not cleared after match");

    // Skid entry is only used behind a full output register
    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_full |-> o_valid)
        else $error("skid holds data while output register is empty");

    // Checks that the checksum holds without a transfer; the window holds likewise
    a_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_accept |=> $stable(r_sum))
        else $error("checksum changed without a byte transfer");
`endif

endmodule
